// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the cycle after a trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/qte_pkg.sv
// Package: widths, constants, arctangent table and helper functions.
package qte_pkg;

  localparam int Q_W    = 32;            // quaternion component width
  localparam int ANG_W  = 16;            // output angle width
  localparam int OP_W   = 64;            // working width of atan2 operands
  localparam int Z_W    = 34;            // angle accumulator, 2^-32 turn units
  localparam int RT_W   = 32;            // square root result width
  localparam int SIDE_W = 5 * OP_W;      // operands carried beside the root unit
  localparam int ANGLE_LIMIT_DEF = 18000;
  localparam int QTR_TURN_CDEG   = 9000;

  localparam int SQ_STEPS  = 32;         // one root bit per stage
  localparam int SQ_TOP    = 62;         // first trial bit position
  localparam int CORDIC_N  = 30;
  localparam int NORM_BIT  = 59;         // normalized magnitude reaches 2^59
  localparam int SH_W      = 6;
  localparam int MAG_W     = Z_W - 1;
  localparam int CPROD_W   = MAG_W + 16;
  localparam int RND_W     = CPROD_W - 32;

  localparam logic signed [OP_W-1:0] ONE_Q56   = OP_W'(64'sd1 <<< 56);
  localparam logic signed [Z_W-1:0]  HALF_TURN = Z_W'(34'sd1 <<< 31);
  localparam logic [15:0]            CDEG_PER_TURN = 16'd36000;
  localparam logic [CPROD_W-1:0]     RND_HALF = CPROD_W'(1) << 31;

  localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic [OP_W-1:0] rem;
    logic [OP_W-1:0] root;
  } sq_t;

  // Q4.60 product to Q.56, truncating toward zero.
  function automatic logic signed [OP_W-1:0] q56(input logic signed [OP_W-1:0] p);
    logic signed [OP_W-1:0] t;
    t = p[OP_W-1] ? (p + OP_W'(64'sd15)) : p;
    return t >>> 4;
  endfunction

  // One step of the bit-pair square root recurrence.
  function automatic sq_t sqrt_step(input sq_t a, input logic [OP_W-1:0] bitv);
    sq_t o;
    logic [OP_W-1:0] t;
    t = a.root + bitv;
    if (a.rem >= t) begin
      o.rem  = a.rem - t;
      o.root = (a.root >> 1) + bitv;
    end else begin
      o.rem  = a.rem;
      o.root = a.root >> 1;
    end
    return o;
  endfunction

endpackage

// File: design/qte_prod.sv
// Product front end: component products, Q.56 sums, pitch sine clamp and root operands.
module qte_prod (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [qte_pkg::Q_W-1:0]     qw,
  input  logic signed [qte_pkg::Q_W-1:0]     qx,
  input  logic signed [qte_pkg::Q_W-1:0]     qy,
  input  logic signed [qte_pkg::Q_W-1:0]     qz,
  output logic                               out_vld,
  output logic signed [qte_pkg::OP_W-1:0]    sin_p,
  output logic signed [qte_pkg::OP_W-1:0]    roll_y,
  output logic signed [qte_pkg::OP_W-1:0]    roll_x,
  output logic signed [qte_pkg::OP_W-1:0]    yaw_y,
  output logic signed [qte_pkg::OP_W-1:0]    yaw_x,
  output logic [qte_pkg::OP_W-1:0]           nu,
  output logic [qte_pkg::OP_W-1:0]           nv
);
  import qte_pkg::*;

  logic p1_vld, p2_vld;
  logic signed [OP_W-1:0] p_wy, p_xz, p_yz, p_wx, p_xx, p_yy, p_zz, p_xy, p_wz;
  logic signed [OP_W-1:0] s2, ry2, rx2, yy2, yx2;
  logic signed [OP_W-1:0] s_cl, a_abs;

  // stage 1: exact products
  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= OP_W'(qw) * OP_W'(qy);
      p_xz <= OP_W'(qx) * OP_W'(qz);
      p_yz <= OP_W'(qy) * OP_W'(qz);
      p_wx <= OP_W'(qw) * OP_W'(qx);
      p_xx <= OP_W'(qx) * OP_W'(qx);
      p_yy <= OP_W'(qy) * OP_W'(qy);
      p_zz <= OP_W'(qz) * OP_W'(qz);
      p_xy <= OP_W'(qx) * OP_W'(qy);
      p_wz <= OP_W'(qw) * OP_W'(qz);
    end
  end

  // stage 2: scale to Q.56 and form the angle operands
  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= (q56(p_wy) - q56(p_xz)) <<< 1;
      ry2 <= (q56(p_yz) + q56(p_wx)) <<< 1;
      rx2 <= ONE_Q56 - ((q56(p_xx) + q56(p_yy)) <<< 1);
      yy2 <= (q56(p_xy) + q56(p_wz)) <<< 1;
      yx2 <= ONE_Q56 - ((q56(p_yy) + q56(p_zz)) <<< 1);
    end
  end

  // stage 3: clamp the sine, build the two root operands
  always_comb begin
    if (s2 > ONE_Q56)       s_cl = ONE_Q56;
    else if (s2 < -ONE_Q56) s_cl = -ONE_Q56;
    else                    s_cl = s2;
    a_abs = s_cl[OP_W-1] ? -s_cl : s_cl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_p  <= s_cl;
      roll_y <= ry2;
      roll_x <= rx2;
      yaw_y  <= yy2;
      yaw_x  <= yx2;
      nu     <= (ONE_Q56 - a_abs) << 6;
      nv     <= (ONE_Q56 + a_abs) << 4;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      p1_vld  <= in_vld;
      p2_vld  <= p1_vld;
      out_vld <= p2_vld;
    end
  end

endmodule

// File: design/qte_sqrt.sv
// Pipelined two-lane integer square root, one result bit per stage, with side data.
module qte_sqrt #(
  parameter int SIDE_W = qte_pkg::SIDE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [qte_pkg::OP_W-1:0]      nu,
  input  logic [qte_pkg::OP_W-1:0]      nv,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_vld,
  output logic [qte_pkg::RT_W-1:0]      ru,
  output logic [qte_pkg::RT_W-1:0]      rv,
  output logic [SIDE_W-1:0]             side_out
);
  import qte_pkg::*;

  sq_t              st_u [0:SQ_STEPS];
  sq_t              st_v [0:SQ_STEPS];
  logic [SIDE_W-1:0] side [0:SQ_STEPS];
  logic             vld  [0:SQ_STEPS];

  assign st_u[0] = '{rem: nu, root: '0};
  assign st_v[0] = '{rem: nv, root: '0};
  assign side[0] = side_in;
  assign vld[0]  = in_vld;

  // one stage per root bit
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [OP_W-1:0] SBIT = OP_W'(1) << (SQ_TOP - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        st_u[k+1] <= sqrt_step(st_u[k], SBIT);
        st_v[k+1] <= sqrt_step(st_v[k], SBIT);
        side[k+1] <= side[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign ru       = st_u[SQ_STEPS].root[RT_W-1:0];
  assign rv       = st_v[SQ_STEPS].root[RT_W-1:0];
  assign side_out = side[SQ_STEPS];
  assign out_vld  = vld[SQ_STEPS];

endmodule

// File: design/qte_atan.sv
// Pipelined atan2: normalize, half-turn fold, CORDIC vectoring, turns to centidegrees.
module qte_atan #(
  parameter int ANGLE_LIMIT = qte_pkg::ANGLE_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [qte_pkg::OP_W-1:0]   op_y,
  input  logic signed [qte_pkg::OP_W-1:0]   op_x,
  output logic                              out_vld,
  output logic signed [qte_pkg::ANG_W-1:0]  angle
);
  import qte_pkg::*;

  logic                   a1_vld, a2_vld, a3_vld, v1_vld;
  logic signed [OP_W-1:0] a1_x, a1_y, a2_x, a2_y;
  logic [OP_W-1:0]        a1_m, abs_x, abs_y;
  logic                   a1_zero, a2_zero;
  logic [SH_W-1:0]        msb, sh;
  logic [SH_W-1:0]        a2_sh;
  logic signed [OP_W-1:0] xs, ys;

  logic signed [OP_W-1:0] cx [0:CORDIC_N];
  logic signed [OP_W-1:0] cy [0:CORDIC_N];
  logic signed [Z_W-1:0]  cz [0:CORDIC_N];
  logic                   cvld [0:CORDIC_N];
  logic                   czero [0:CORDIC_N];

  logic [MAG_W-1:0]       mag;
  logic [CPROD_W-1:0]     v1_prod;
  logic                   v1_neg;
  logic [CPROD_W-1:0]     rnd_sum;
  logic [RND_W-1:0]       rnd;
  logic [ANG_W-1:0]       mag_cd;

  // stage A1: magnitudes and the larger of the two
  always_comb begin
    abs_x = op_x[OP_W-1] ? OP_W'(-op_x) : OP_W'(op_x);
    abs_y = op_y[OP_W-1] ? OP_W'(-op_y) : OP_W'(op_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_x    <= op_x;
      a1_y    <= op_y;
      a1_m    <= (abs_x > abs_y) ? abs_x : abs_y;
      a1_zero <= (op_x == '0) && (op_y == '0);
    end
  end

  // stage A2: leading one position gives the normalizing shift
  always_comb begin
    msb = '0;
    for (int i = 0; i < NORM_BIT; i++) begin
      if (a1_m[i]) msb = SH_W'(i);
    end
    sh = (|a1_m[OP_W-1:NORM_BIT]) ? '0 : SH_W'(NORM_BIT) - msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_x    <= a1_x;
      a2_y    <= a1_y;
      a2_sh   <= sh;
      a2_zero <= a1_zero;
    end
  end

  // stage A3: shift, then fold the left half plane
  always_comb begin
    xs = a2_x <<< a2_sh;
    ys = a2_y <<< a2_sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a2_zero) begin
        cx[0] <= '0;
        cy[0] <= '0;
        cz[0] <= '0;
      end else if (xs[OP_W-1]) begin
        cx[0] <= -xs;
        cy[0] <= -ys;
        cz[0] <= ys[OP_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
        cx[0] <= xs;
        cy[0] <= ys;
        cz[0] <= '0;
      end
      czero[0] <= a2_zero;
    end
  end

  // CORDIC vectoring stages
  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ZSTEP = $signed({2'b00, ATAN_TAB[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[k][OP_W-1]) begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + ZSTEP;
        end else begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - ZSTEP;
        end
        czero[k+1] <= czero[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[k+1] <= 1'b0;
      end else if (en) begin
        cvld[k+1] <= cvld[k];
      end
    end
  end

  // stage V1: scale turn units to centidegrees
  always_comb begin
    if (czero[CORDIC_N])              mag = '0;
    else if (cz[CORDIC_N][Z_W-1])     mag = MAG_W'(-cz[CORDIC_N]);
    else                              mag = MAG_W'(cz[CORDIC_N]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_prod <= CPROD_W'(mag) * CPROD_W'(CDEG_PER_TURN);
      v1_neg  <= cz[CORDIC_N][Z_W-1] && !czero[CORDIC_N];
    end
  end

  // stage V2: round half away from zero, saturate, sign
  always_comb begin
    rnd_sum = v1_prod + RND_HALF;
    rnd     = rnd_sum[CPROD_W-1:32];
    mag_cd  = (rnd > RND_W'(ANGLE_LIMIT)) ? ANG_W'(ANGLE_LIMIT) : ANG_W'(rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= v1_neg ? -$signed(mag_cd) : $signed(mag_cd);
    end
  end

  // valid bits; cvld[0] goes with the folded vector in stage A3
  assign cvld[0] = a3_vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_vld  <= 1'b0;
      a2_vld  <= 1'b0;
      a3_vld  <= 1'b0;
      v1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a1_vld  <= in_vld;
      a2_vld  <= a1_vld;
      a3_vld  <= a2_vld;
      v1_vld  <= cvld[CORDIC_N];
      out_vld <= v1_vld;
    end
  end

endmodule

// File: design/quaternion_to_euler_centideg_core.sv
// Top level: quaternion in, Z-Y-X Euler angles in centidegrees out.
//
// Input channel: quat_w/x/y/z (signed Q2.30) with quat_valid/quat_ready.
// Output channel: yaw/pitch/roll_centideg (signed, +-ANGLE_LIMIT) with
// euler_valid/euler_ready. One result word for every input word, in order.
// Throughput: one word per cycle while the receiver takes results.
// Pipeline: 71 register stages, namely 3 product/sum stages, 32 square root
// stages (one root bit each; all three angle lanes pass through them), 1 cosine
// multiply, then per angle 3 normalize stages, 30 CORDIC stages and 2 conversion
// stages.
// The whole pipeline moves on one enable: it advances when the output
// register is empty or being taken. While the receiver stalls with a word
// waiting, every stage holds and quat_ready is low; nothing is lost or
// repeated. Empty slots still move forward while the output is free.
// Reset (synchronous, active high) clears all valid bits and holds quat_ready
// low; no clearing pass.
// The block holds no state between words.
module quaternion_to_euler_centideg_core #(
  parameter int ANGLE_LIMIT = qte_pkg::ANGLE_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              quat_valid,
  output logic                              quat_ready,
  input  logic signed [qte_pkg::Q_W-1:0]    quat_w,
  input  logic signed [qte_pkg::Q_W-1:0]    quat_x,
  input  logic signed [qte_pkg::Q_W-1:0]    quat_y,
  input  logic signed [qte_pkg::Q_W-1:0]    quat_z,
  output logic                              euler_valid,
  input  logic                              euler_ready,
  output logic signed [qte_pkg::ANG_W-1:0]  yaw_centideg,
  output logic signed [qte_pkg::ANG_W-1:0]  pitch_centideg,
  output logic signed [qte_pkg::ANG_W-1:0]  roll_centideg
);
  import qte_pkg::*;
  `include "assert_macros.svh"

  logic                   en;
  logic                   pr_vld, sq_vld, m_vld;
  logic                   yaw_vld, pitch_vld, roll_vld;
  logic signed [OP_W-1:0] sin_p, roll_y, roll_x, yaw_y, yaw_x;
  logic [OP_W-1:0]        nu, nv;
  logic [SIDE_W-1:0]      side_in, side_out, m_side;
  logic [RT_W-1:0]        ru, rv;
  logic [OP_W-1:0]        cos_q61;
  logic signed [OP_W-1:0] cos_q56;

  // global advance
  assign en          = !euler_valid || euler_ready;
  assign quat_ready  = en && !rst;
  assign euler_valid = pitch_vld;

  qte_prod u_prod (
    .clk, .rst, .en,
    .in_vld (quat_valid),
    .qw (quat_w), .qx (quat_x), .qy (quat_y), .qz (quat_z),
    .out_vld (pr_vld),
    .sin_p, .roll_y, .roll_x, .yaw_y, .yaw_x, .nu, .nv
  );

  assign side_in = {sin_p, roll_y, roll_x, yaw_y, yaw_x};

  qte_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst, .en,
    .in_vld (pr_vld),
    .nu, .nv, .side_in,
    .out_vld (sq_vld),
    .ru, .rv, .side_out
  );

  // cosine of pitch: product of the two roots
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q61 <= {32'b0, ru} * {32'b0, rv};
      m_side  <= side_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= sq_vld;
    end
  end

  assign cos_q56 = $signed(cos_q61 >> 5);

  qte_atan #(.ANGLE_LIMIT(ANGLE_LIMIT)) u_atan_pitch (
    .clk, .rst, .en, .in_vld (m_vld),
    .op_y (m_side[5*OP_W-1:4*OP_W]), .op_x (cos_q56),
    .out_vld (pitch_vld), .angle (pitch_centideg)
  );

  qte_atan #(.ANGLE_LIMIT(ANGLE_LIMIT)) u_atan_roll (
    .clk, .rst, .en, .in_vld (m_vld),
    .op_y (m_side[4*OP_W-1:3*OP_W]), .op_x (m_side[3*OP_W-1:2*OP_W]),
    .out_vld (roll_vld), .angle (roll_centideg)
  );

  qte_atan #(.ANGLE_LIMIT(ANGLE_LIMIT)) u_atan_yaw (
    .clk, .rst, .en, .in_vld (m_vld),
    .op_y (m_side[2*OP_W-1:OP_W]), .op_x (m_side[OP_W-1:0]),
    .out_vld (yaw_vld), .angle (yaw_centideg)
  );

  // checks
  `ASSERT_IMPLY(a_lanes_aligned, pitch_vld || roll_vld || yaw_vld,
    pitch_vld && roll_vld && yaw_vld, "angle lanes out of step")
  `ASSERT_IMPLY(a_pitch_range, euler_valid,
    (pitch_centideg <= 16'(QTR_TURN_CDEG)) && (pitch_centideg >= -16'(QTR_TURN_CDEG)),
    "pitch beyond a quarter turn")
  `ASSERT_IMPLY(a_yaw_range, euler_valid,
    (yaw_centideg <= 16'(ANGLE_LIMIT)) && (yaw_centideg >= -16'(ANGLE_LIMIT)),
    "yaw beyond limit")
  `ASSERT_NEXT(a_hold_on_stall, euler_valid && !euler_ready,
    euler_valid && $stable(roll_centideg), "result changed during stall")

endmodule
